[rtl/btb_pkg.sv]
// ----------------------------------------------------------------------------
// Branch target buffer package
// Shared types and codes for the branch target buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package btb_pkg;

  localparam int unsigned AddrWidth   = 32;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 8;
  localparam int unsigned StateWidth  = 2;

  localparam logic [7:0] ResetNextTaken    = 8'd249;
  localparam logic [7:0] ResetNextNotTaken = 8'd144;
  localparam logic [3:0] ResetTakenMask    = 4'd12;
  localparam logic [1:0] ResetInitState    = 2'd0;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_NEXT_TAKEN     = 2'd0,
    CFG_NEXT_NOT_TAKEN = 2'd1,
    CFG_TAKEN_MASK     = 2'd2,
    CFG_INIT_STATE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OUT_NONE        = 3'd0,
    OUT_RIGHT       = 3'd1,
    OUT_WRONG_DIR   = 3'd2,
    OUT_WRONG_TGT   = 3'd3,
    OUT_ALLOCATED   = 3'd4,
    OUT_REPLACED    = 3'd5,
    OUT_LOOKUP_ONLY = 3'd6
  } outcome_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } btb_state_e;

  typedef struct packed {
    logic [AddrWidth-1:0] pc;
    logic [AddrWidth-1:0] next_pc;
    logic                 last_in_trace;
  } btb_item_t;

  typedef struct packed {
    logic [7:0]            next_taken;
    logic [7:0]            next_not_taken;
    logic [3:0]            taken_mask;
    logic [StateWidth-1:0] init_state;
  } btb_cfg_t;

  typedef struct packed {
    logic                 hit;
    logic                 actual_taken;
    logic                 predicted_taken;
    logic [AddrWidth-1:0] predicted_target;
    outcome_e             outcome;
  } btb_result_t;

endpackage

`default_nettype wire

[rtl/btb_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/btb_update.sv]
// ----------------------------------------------------------------------------
// Branch target buffer entry update
// Classifies a looked-up entry against the executed branch and forms the
// entry to write back together with the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module btb_update
  import btb_pkg::*;
#(
  parameter int unsigned IndexBits = 10
) (
  input  wire btb_item_t                           item_i,
  input  wire logic [AddrWidth-IndexBits+34:0]     entry_i,
  input  wire btb_cfg_t                            cfg_i,
  output btb_result_t                              res_o,
  output logic                                     we_o,
  output logic [AddrWidth-IndexBits+34:0]          entry_o
);

  localparam int unsigned TagWidth = AddrWidth - IndexBits;

  logic                  e_valid;
  logic [TagWidth-1:0]   e_tag;
  logic [AddrWidth-1:0]  e_target;
  logic [StateWidth-1:0] e_state;
  logic [TagWidth-1:0]   tag;
  logic [AddrWidth-1:0]  seq_pc;
  logic                  hit;
  logic                  pred;
  logic                  taken;
  logic [StateWidth-1:0] adv_state;

  assign {e_valid, e_tag, e_target, e_state} = entry_i;
  assign tag    = {item_i.pc[AddrWidth-1:IndexBits+2], item_i.pc[1:0]};
  assign seq_pc = item_i.pc + AddrWidth'(4);
  assign hit    = e_valid && (e_tag == tag);
  assign pred   = cfg_i.taken_mask[e_state];
  assign taken  = item_i.next_pc != seq_pc;

  always_comb begin
    if (taken) begin
      adv_state = cfg_i.next_taken[{e_state, 1'b0} +: StateWidth];
    end else begin
      adv_state = cfg_i.next_not_taken[{e_state, 1'b0} +: StateWidth];
    end
  end

  always_comb begin
    res_o.hit              = hit;
    res_o.actual_taken     = 1'b0;
    res_o.predicted_taken  = hit && pred;
    res_o.predicted_target = hit ? e_target : '0;
    res_o.outcome          = OUT_NONE;
    we_o                   = 1'b0;
    entry_o                = entry_i;
    priority if (item_i.last_in_trace) begin
      res_o.outcome = OUT_LOOKUP_ONLY;
    end else if (hit) begin
      res_o.actual_taken = taken;
      we_o               = 1'b1;
      if (pred != taken) begin
        res_o.outcome = OUT_WRONG_DIR;
        entry_o       = {1'b1, e_tag, e_target, adv_state};
      end else if (taken && (item_i.next_pc != e_target)) begin
        res_o.outcome = OUT_WRONG_TGT;
        entry_o       = {1'b1, e_tag, item_i.next_pc, adv_state};
      end else begin
        res_o.outcome = OUT_RIGHT;
        entry_o       = {1'b1, e_tag, e_target, adv_state};
      end
    end else if (taken) begin
      res_o.actual_taken = 1'b1;
      res_o.outcome      = e_valid ? OUT_REPLACED : OUT_ALLOCATED;
      we_o               = 1'b1;
      entry_o            = {1'b1, tag, item_i.next_pc, cfg_i.init_state};
    end else begin
      res_o.outcome = OUT_NONE;
    end
  end

endmodule

`default_nettype wire

[rtl/branch_target_buffer.sv]
// ----------------------------------------------------------------------------
// Branch target buffer
// Pipeline: an input beat is registered with the table's read data, and its
// result beat is registered when the output is free; a stalled output holds
// the lookup until the result is taken. A new item is taken only once the
// previous lookup has loaded its result: the entry is read, then written back.
// Reset: configuration takes its defaults and a sweep over every index
// clears every entry's valid bit; inputs are stalled during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module branch_target_buffer
  import btb_pkg::*;
#(
  parameter int unsigned IndexBits = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [CfgWidth-1:0]    cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [AddrWidth-1:0]   in_pc_i,
  input  wire logic [AddrWidth-1:0]   in_next_pc_i,
  input  wire logic                   in_last_in_trace_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        out_hit_o,
  output logic                        out_actual_taken_o,
  output logic                        out_predicted_taken_o,
  output logic [AddrWidth-1:0]        out_predicted_target_o,
  output logic [2:0]                  out_outcome_o
);

  localparam int unsigned EntryWidth = AddrWidth - IndexBits + 35;
  localparam int unsigned Depth      = 2 ** IndexBits;

  btb_state_e             state_q, state_d;
  logic [IndexBits-1:0]   clr_q, clr_d;
  btb_cfg_t               cfg_q;
  btb_item_t              item_q;
  btb_result_t            res_q, res;
  logic                   out_valid_q, out_valid_d;
  logic                   in_accept;
  logic                   load;
  logic                   upd_we;
  logic                   ram_we;
  logic                   ram_re;
  logic [IndexBits-1:0]   ram_waddr;
  logic [EntryWidth-1:0]  ram_wdata;
  logic [EntryWidth-1:0]  ram_rdata;
  logic [EntryWidth-1:0]  upd_entry;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + IndexBits'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    load       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = item_q.pc[IndexBits+1:2];
    ram_wdata  = upd_entry;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_LOOKUP: begin
        load   = !out_valid_q || !out_stall_i;
        ram_we = load && upd_we;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign ram_re = in_accept;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= '{next_taken:     ResetNextTaken,
                       next_not_taken: ResetNextNotTaken,
                       taken_mask:     ResetTakenMask,
                       init_state:     ResetInitState};
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_NEXT_TAKEN:     cfg_q.next_taken     <= cfg_data_i;
          CFG_NEXT_NOT_TAKEN: cfg_q.next_not_taken <= cfg_data_i;
          CFG_TAKEN_MASK:     cfg_q.taken_mask     <= cfg_data_i[3:0];
          CFG_INIT_STATE:     cfg_q.init_state     <= cfg_data_i[StateWidth-1:0];
          default:            cfg_q                <= cfg_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{pc: in_pc_i, next_pc: in_next_pc_i, last_in_trace: in_last_in_trace_i};
    end
    if (load) begin
      res_q <= res;
    end
  end

  btb_ram #(
    .Width (EntryWidth),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_pc_i[IndexBits+1:2]),
    .rdata_o (ram_rdata)
  );

  btb_update #(
    .IndexBits (IndexBits)
  ) u_update (
    .item_i  (item_q),
    .entry_i (ram_rdata),
    .cfg_i   (cfg_q),
    .res_o   (res),
    .we_o    (upd_we),
    .entry_o (upd_entry)
  );

  assign out_valid_o            = out_valid_q;
  assign out_hit_o              = res_q.hit;
  assign out_actual_taken_o     = res_q.actual_taken;
  assign out_predicted_taken_o  = res_q.predicted_taken;
  assign out_predicted_target_o = res_q.predicted_target;
  assign out_outcome_o          = res_q.outcome;

`ifndef SYNTHESIS
  a_result_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_LOOKUP))
    else $error("Result beat loaded outside of a lookup.");

  a_write_in_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_LOOKUP || state_q == ST_CLEAR))
    else $error("Table written outside of a lookup or the clearing sweep.");

  a_accept_starts_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_LOOKUP))
    else $error("Accepted beat did not start a lookup.");

  a_no_load_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load)
    else $error("Result register overwritten while stalled.");
`endif

endmodule

`default_nettype wire
